// ----- rtl/ev1527_pkg.sv -----
// Shared types, constants and the sub-bit level function for the EV1527 transmitter.
// No dependencies; used by the input and config interfaces, the core and the top level.
package ev1527_pkg;

    localparam int unsigned ADDR_W      = 20;
    localparam int unsigned NIBBLE_W    = 4;
    localparam int unsigned CODE_W      = ADDR_W + NIBBLE_W;
    localparam int unsigned TPS_W       = 6;
    localparam int unsigned REPEAT_W    = 8;
    localparam int unsigned GAP_W       = 16;
    localparam int unsigned SUB_IDX_W   = 7;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [SUB_IDX_W-1:0] PREAMBLE_SUBS = 7'd32;
    localparam logic [SUB_IDX_W-1:0] LAST_SUB      = 7'd127;

    localparam logic [TPS_W-1:0]    TPS_RESET    = 6'd45;
    localparam logic [REPEAT_W-1:0] REPEAT_RESET = 8'd50;
    localparam logic [GAP_W-1:0]    GAP_RESET    = 16'd125;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SUB = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_TICKS     = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_GAP   = 2'd1,
        PH_FRAME = 2'd2
    } phase_t;

    typedef struct packed {
        logic [TPS_W-1:0]    ticks_per_sub_bit;
        logic [REPEAT_W-1:0] repeat_count;
        logic [GAP_W-1:0]    gap_ticks;
    } cfg_t;

    typedef struct packed {
        logic                opcode;
        logic [ADDR_W-1:0]   address;
        logic [NIBBLE_W-1:0] data_nibble;
    } item_t;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic load_accepted;
    } result_t;

    // Level of one sub-bit: preamble is one high then 31 low, then each code bit
    // MSB first as 1,b,b,0.
    function automatic logic sub_bit_level(input logic [SUB_IDX_W-1:0] idx,
                                           input logic [CODE_W-1:0]    code);
        logic [SUB_IDX_W-1:0] k;
        logic [4:0]           bitpos;
        logic                 lvl;
        k      = idx - PREAMBLE_SUBS;
        bitpos = 5'd23 - k[6:2];
        if (idx < PREAMBLE_SUBS)
            lvl = (idx == '0);
        else if (k[1:0] == 2'd0)
            lvl = 1'b1;
        else if (k[1:0] == 2'd3)
            lvl = 1'b0;
        else
            lvl = code[bitpos];
        return lvl;
    endfunction

endpackage

// ----- rtl/ev1527_in_if.sv -----
// Input channel: valid/ready handshake carrying one tick or load item.
// Depends on ev1527_pkg for field widths.
interface ev1527_in_if;
    import ev1527_pkg::*;

    logic                valid;
    logic                ready;
    logic                opcode;
    logic [ADDR_W-1:0]   address;
    logic [NIBBLE_W-1:0] data_nibble;

    modport source (output valid, opcode, address, data_nibble, input ready);
    modport sink   (input valid, opcode, address, data_nibble, output ready);
endinterface

// ----- rtl/ev1527_out_if.sv -----
// Output channel: valid/ready handshake carrying one result per item.
// No dependencies.
interface ev1527_out_if;
    logic valid;
    logic ready;
    logic line_level;
    logic busy_res;
    logic load_accepted;

    modport source (output valid, line_level, busy_res, load_accepted, input ready);
    modport sink   (input valid, line_level, busy_res, load_accepted, output ready);
endinterface

// ----- rtl/ev1527_cfg_if.sv -----
// Configuration write channel: valid/ready, register index and write data.
// Depends on ev1527_pkg for widths.
interface ev1527_cfg_if;
    import ev1527_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/ev1527_ook_frame_transmitter_top.sv -----
// EV1527 OOK frame transmitter: top level with config registers and result register.
// Depends on ev1527_pkg, the three channel interfaces and ev1527_core.
// The result is registered and valid in the cycle after the input transaction.
// Throughput: one item per cycle; the single result register is refilled in the
// cycle it is drained, so the input stalls only while a result waits unread.
// Reset: idle, no frame pending, config at 45 ticks/sub-bit, 50 repeats, 125 gap ticks.
module ev1527_ook_frame_transmitter_top (
    input  logic         clk,
    input  logic         rst_n,
    ev1527_in_if.sink    in_ch,
    ev1527_out_if.source out_ch,
    ev1527_cfg_if.sink   cfg
);
    import ev1527_pkg::*;

    cfg_t    cfg_reg;
    item_t   item;
    result_t result;
    result_t result_reg;
    logic    out_valid_reg;
    logic    accept;

    assign cfg.ready   = 1'b1;
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    assign item.opcode      = in_ch.opcode;
    assign item.address     = in_ch.address;
    assign item.data_nibble = in_ch.data_nibble;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ticks_per_sub_bit <= TPS_RESET;
            cfg_reg.repeat_count      <= REPEAT_RESET;
            cfg_reg.gap_ticks         <= GAP_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_TICKS_PER_SUB: cfg_reg.ticks_per_sub_bit <= cfg.data[TPS_W-1:0];
                CFG_REPEAT_COUNT:  cfg_reg.repeat_count      <= cfg.data[REPEAT_W-1:0];
                CFG_GAP_TICKS:     cfg_reg.gap_ticks         <= cfg.data[GAP_W-1:0];
                default:           ;
            endcase
        end
    end

    ev1527_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .cfg    (cfg_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_ch.ready)
            out_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result;
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.line_level    = result_reg.line_level;
    assign out_ch.busy_res      = result_reg.busy_res;
    assign out_ch.load_accepted = result_reg.load_accepted;

endmodule

// ----- rtl/ev1527_core.sv -----
// Transmit sequencer: phase, sub-bit and gap counters, code word, and the
// per-item result. Depends on ev1527_pkg.
module ev1527_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  ev1527_pkg::item_t   item,
    input  ev1527_pkg::cfg_t    cfg,
    output ev1527_pkg::result_t result
);
    import ev1527_pkg::*;

    logic [CODE_W-1:0]    code_word_reg,       code_word_next;
    phase_t               phase_reg,           phase_next;
    logic [SUB_IDX_W-1:0] sub_bit_index_reg,   sub_bit_index_next;
    logic [TPS_W-1:0]     tick_in_sub_bit_reg, tick_in_sub_bit_next;
    logic [REPEAT_W-1:0]  frames_left_reg,     frames_left_next;
    logic [GAP_W-1:0]     gap_count_reg,       gap_count_next;

    logic                 busy;
    logic                 is_load;
    logic                 gap_done;
    logic                 frame_step;
    logic [SUB_IDX_W-1:0] base_sub;
    logic [TPS_W-1:0]     base_tick;
    logic [TPS_W-1:0]     tick_inc;
    logic [TPS_W-1:0]     limit;
    logic                 sub_end;
    logic [REPEAT_W-1:0]  frames_dec;
    logic                 level;

    assign busy     = (phase_reg == PH_GAP) || (phase_reg == PH_FRAME);
    assign is_load  = (item.opcode == OP_LOAD);
    assign gap_done = (phase_reg == PH_GAP) && (gap_count_reg >= cfg.gap_ticks);
    assign frame_step = !is_load && (gap_done || (phase_reg == PH_FRAME));

    // A frame entered from the gap starts at sub-bit zero on this very tick.
    assign base_sub   = gap_done ? '0 : sub_bit_index_reg;
    assign base_tick  = gap_done ? '0 : tick_in_sub_bit_reg;
    assign tick_inc   = base_tick + 1'b1;
    assign limit      = (cfg.ticks_per_sub_bit == '0) ? TPS_W'(1) : cfg.ticks_per_sub_bit;
    assign sub_end    = (tick_inc >= limit) || (tick_inc == '0);
    assign frames_dec = (frames_left_reg != '0) ? frames_left_reg - 1'b1 : frames_left_reg;
    assign level      = sub_bit_level(base_sub, code_word_reg);

    // Next state
    always_comb
    begin
        code_word_next       = code_word_reg;
        phase_next           = phase_reg;
        sub_bit_index_next   = sub_bit_index_reg;
        tick_in_sub_bit_next = tick_in_sub_bit_reg;
        frames_left_next     = frames_left_reg;
        gap_count_next       = gap_count_reg;
        if (is_load)
        begin
            if (!busy)
            begin
                code_word_next       = {item.address, item.data_nibble};
                frames_left_next     = cfg.repeat_count;
                sub_bit_index_next   = '0;
                tick_in_sub_bit_next = '0;
                gap_count_next       = '0;
                phase_next           = (cfg.repeat_count != '0) ? PH_GAP : PH_IDLE;
            end
        end
        else if (frame_step)
        begin
            phase_next           = PH_FRAME;
            sub_bit_index_next   = base_sub;
            tick_in_sub_bit_next = tick_inc;
            if (sub_end)
            begin
                tick_in_sub_bit_next = '0;
                if (base_sub == LAST_SUB)
                begin
                    sub_bit_index_next = '0;
                    frames_left_next   = frames_dec;
                    if (frames_dec != '0)
                    begin
                        phase_next     = PH_GAP;
                        gap_count_next = '0;
                    end
                    else
                        phase_next = PH_IDLE;
                end
                else
                    sub_bit_index_next = base_sub + 1'b1;
            end
        end
        else if (phase_reg == PH_GAP)
            gap_count_next = gap_count_reg + 1'b1;
    end

    // Outputs
    always_comb
    begin
        result.line_level    = frame_step && level;
        result.busy_res      = (phase_next == PH_GAP) || (phase_next == PH_FRAME);
        result.load_accepted = is_load && !busy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_word_reg       <= '0;
            phase_reg           <= PH_IDLE;
            sub_bit_index_reg   <= '0;
            tick_in_sub_bit_reg <= '0;
            frames_left_reg     <= '0;
            gap_count_reg       <= '0;
        end
        else if (accept)
        begin
            code_word_reg       <= code_word_next;
            phase_reg           <= phase_next;
            sub_bit_index_reg   <= sub_bit_index_next;
            tick_in_sub_bit_reg <= tick_in_sub_bit_next;
            frames_left_reg     <= frames_left_next;
            gap_count_reg       <= gap_count_next;
        end
    end

endmodule
